[rtl/core/class_token_stream_decoder_core_defines.svh]
// Assertion helpers shared by the decoder core files.
`ifndef CLASS_TOKEN_STREAM_DECODER_CORE_DEFINES_SVH
`define CLASS_TOKEN_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CTSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CTSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ctsd_pkg.sv]
`timescale 1ns / 1ps
package ctsd_pkg;

    localparam int VALUE_BITS      = 32;
    localparam int MAX_TOKEN_BYTES = 127;

    localparam logic [7:0] HEADER_MAGIC   = 8'hA2;
    localparam logic [7:0] OLD_VERSION    = 8'd1;
    localparam logic [7:0] HEADER_MAX_OLD = 8'd5;
    localparam logic [7:0] CMD_LINE_END   = 8'd0;
    localparam logic [7:0] CMD_SKIP_GAP   = 8'd128;
    localparam logic [7:0] CMD_FLEX_GAP   = 8'd129;

    localparam logic [7:0] CFG_FIRST_LINE      = 8'd0;
    localparam logic [7:0] CFG_LAST_LINE       = 8'd1;
    localparam logic [7:0] CFG_DELIMITER_CLASS = 8'd2;

    localparam logic [2:0] KIND_CLASS    = 3'd0;
    localparam logic [2:0] KIND_LINE_END = 3'd1;
    localparam logic [2:0] KIND_SKIP_GAP = 3'd2;
    localparam logic [2:0] KIND_FLEX_GAP = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    typedef struct packed {
        logic [31:0] first_line;
        logic [31:0] last_line;
        logic [31:0] delimiter_class;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [31:0] class_id;
        logic [31:0] line_number;
    } t_result;

endpackage

[rtl/core/class_token_stream_decoder_core.sv]
`timescale 1ns / 1ps
// Byte-stream decoder for class-token corpora.
// Input channel (i_in_valid / o_in_ready): one corpus byte per transaction,
// with i_in_start_of_file marking the first byte of each file.
// Output channel (o_out_valid / i_out_ready): zero or one event per byte:
// class token, line end, skip gap, flexible gap or format error, each with
// the line number it belongs to. Line-range filtering drops events other than
// format errors outside first_line..last_line unless both are zero.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 first_line, 1 last_line,
// 2 delimiter_class; always ready; write only while the block is idle.
// Throughput: one byte per cycle while the skid entry is empty; each byte is
// decoded in the cycle it is accepted by the parse state update.
// Events are registered in the output register, or the skid entry on a stall.
// Receiver stall: the output register plus a one-entry skid buffer absorb
// one extra result; o_in_ready drops only while the skid entry is full.
// Reset (synchronous, active low): awaits a header byte, line count one,
// registers zero, output empty.
`include "class_token_stream_decoder_core_defines.svh"
module class_token_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_data_byte,
    input  logic        i_in_start_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_out_kind,
    output logic [31:0] o_out_class_id,
    output logic [31:0] o_out_line_number,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ctsd_pkg::*;

    t_cfg    r_cfg;
    t_result r_out;
    t_result r_skid;
    t_result w_res;
    logic    in_accept;

    assign o_in_ready  = !r_skid.valid;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;

    ctsd_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_data_byte     (i_in_data_byte),
        .i_start_of_file (i_in_start_of_file),
        .i_cfg           (r_cfg),
        .o_result        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= '0;
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FIRST_LINE:      r_cfg.first_line      <= i_cfg_data;
                    CFG_LAST_LINE:       r_cfg.last_line       <= i_cfg_data;
                    CFG_DELIMITER_CLASS: r_cfg.delimiter_class <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_skid.valid) begin
                if (i_out_ready) begin
                    r_out        <= r_skid;
                    r_skid.valid <= 1'b0;
                end
            end else if (!r_out.valid || i_out_ready) begin
                r_out <= w_res;
            end else if (w_res.valid) begin
                r_skid <= w_res;
            end
        end
    end

    assign o_out_valid       = r_out.valid;
    assign o_out_kind        = r_out.kind;
    assign o_out_class_id    = r_out.class_id;
    assign o_out_line_number = r_out.line_number;

    `CTSD_ASSERT_NOW(a_skid_behind_out, r_skid.valid, r_out.valid,
        "skid entry held with empty output register")
    `CTSD_ASSERT_NEXT(a_skid_fill_on_stall,
        !r_skid.valid && r_out.valid && !i_out_ready && w_res.valid, r_skid.valid,
        "stalled result not captured in skid entry")

endmodule

[rtl/core/ctsd_parse.sv]
`timescale 1ns / 1ps
`include "class_token_stream_decoder_core_defines.svh"
module ctsd_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_start_of_file,
    input  ctsd_pkg::t_cfg   i_cfg,
    output ctsd_pkg::t_result o_result
);
    import ctsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_VERSION,
        PH_VARINT,
        PH_OLD_CMD,
        PH_OLD_DATA,
        PH_HALTED
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [VALUE_BITS-1:0]   r_acc, n_acc;
    logic [2:0]              r_pos, n_pos;
    logic [6:0]              r_rem, n_rem;
    logic [31:0]             r_line_count, n_line_count;

    t_phase                  c_phase;
    logic [VALUE_BITS-1:0]   c_acc;
    logic [2:0]              c_pos;
    logic [6:0]              c_rem;
    logic [31:0]             c_line;

    logic                    do_cmd;
    logic                    emit;
    logic                    emit_filtered;
    logic [2:0]              emit_kind;
    logic [VALUE_BITS-1:0]   emit_value;
    logic                    line_sel;
    logic [7:0]              digit;
    logic [5:0]              shamt;
    logic [VALUE_BITS-1:0]   acc_sum;
    logic [2:0]              pos_inc;
    logic [6:0]              len;

    always_comb begin
        c_phase = r_phase;
        c_acc   = r_acc;
        c_pos   = r_pos;
        c_rem   = r_rem;
        c_line  = r_line_count;
        if (i_start_of_file) begin
            c_phase = PH_HEADER;
            c_acc   = '0;
            c_pos   = '0;
            c_rem   = '0;
            c_line  = 32'd1;
        end

        // weighted add of the current digit
        if (c_phase == PH_VARINT) begin
            digit = {1'b0, i_data_byte[6:0]};
            shamt = 6'(c_pos) * 6'd7;
        end else begin
            digit = i_data_byte;
            shamt = {c_pos, 3'b000};
        end
        if (c_pos != 3'd7 && 32'(shamt) < 32'(VALUE_BITS)) begin
            acc_sum = c_acc + (VALUE_BITS'(digit) << shamt);
        end else begin
            acc_sum = c_acc;
        end
        pos_inc = (c_pos != 3'd7) ? c_pos + 3'd1 : c_pos;

        len = (i_data_byte[6:0] > 7'(MAX_TOKEN_BYTES)) ? 7'(MAX_TOKEN_BYTES)
                                                        : i_data_byte[6:0];

        n_phase       = c_phase;
        n_acc         = c_acc;
        n_pos         = c_pos;
        n_rem         = c_rem;
        n_line_count  = c_line;
        do_cmd        = 1'b0;
        emit          = 1'b0;
        emit_filtered = 1'b1;
        emit_kind     = KIND_CLASS;
        emit_value    = '0;

        unique case (c_phase)
            PH_HEADER: begin
                if (i_data_byte == HEADER_MAGIC) begin
                    n_phase = PH_VERSION;
                end else if (i_data_byte > HEADER_MAX_OLD) begin
                    n_phase       = PH_HALTED;
                    emit          = 1'b1;
                    emit_filtered = 1'b0;
                    emit_kind     = KIND_ERROR;
                end else begin
                    n_phase = PH_OLD_CMD;
                    do_cmd  = 1'b1;
                end
            end
            PH_VERSION: begin
                n_phase = (i_data_byte == OLD_VERSION) ? PH_OLD_CMD : PH_VARINT;
                n_acc   = '0;
                n_pos   = '0;
            end
            PH_VARINT: begin
                n_acc = acc_sum;
                n_pos = pos_inc;
                if (!i_data_byte[7]) begin
                    n_acc = '0;
                    n_pos = '0;
                    emit  = 1'b1;
                    if (64'(acc_sum) == 64'(i_cfg.delimiter_class)) begin
                        emit_kind    = KIND_LINE_END;
                        n_line_count = c_line + 32'd1;
                    end else begin
                        emit_kind  = KIND_CLASS;
                        emit_value = acc_sum;
                    end
                end
            end
            PH_OLD_CMD: begin
                do_cmd = 1'b1;
            end
            PH_OLD_DATA: begin
                n_acc = acc_sum;
                n_pos = pos_inc;
                n_rem = (c_rem != 7'd0) ? c_rem - 7'd1 : c_rem;
                if (n_rem == 7'd0) begin
                    n_acc      = '0;
                    n_pos      = '0;
                    n_phase    = PH_OLD_CMD;
                    emit       = 1'b1;
                    emit_kind  = KIND_CLASS;
                    emit_value = acc_sum;
                end
            end
            default: begin
                n_phase = PH_HALTED;
            end
        endcase

        if (do_cmd) begin
            if (i_data_byte == CMD_LINE_END) begin
                emit         = 1'b1;
                emit_kind    = KIND_LINE_END;
                n_line_count = c_line + 32'd1;
            end else if (!i_data_byte[7]) begin
                n_acc   = '0;
                n_pos   = '0;
                n_rem   = len;
                n_phase = PH_OLD_DATA;
            end else if (i_data_byte == CMD_SKIP_GAP) begin
                emit      = 1'b1;
                emit_kind = KIND_SKIP_GAP;
            end else if (i_data_byte == CMD_FLEX_GAP) begin
                emit      = 1'b1;
                emit_kind = KIND_FLEX_GAP;
            end
        end

        line_sel = (i_cfg.first_line == 32'd0 && i_cfg.last_line == 32'd0) ||
                   (c_line >= i_cfg.first_line && c_line <= i_cfg.last_line);

        o_result.valid       = i_accept && emit && (!emit_filtered || line_sel);
        o_result.kind        = emit_kind;
        o_result.class_id    = 32'(emit_value);
        o_result.line_number = c_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_acc        <= '0;
            r_pos        <= '0;
            r_rem        <= '0;
            r_line_count <= 32'd1;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_pos        <= n_pos;
            r_rem        <= n_rem;
            r_line_count <= n_line_count;
        end
    end

    `CTSD_ASSERT_NOW(a_halted_silent,
        i_accept && !i_start_of_file && r_phase == PH_HALTED, !o_result.valid,
        "result produced while halted")
    `CTSD_ASSERT_NOW(a_error_on_line_one,
        o_result.valid && o_result.kind == KIND_ERROR, o_result.line_number == 32'd1,
        "format error not on line one")
    `CTSD_ASSERT_NOW(a_class_id_zero,
        o_result.valid && o_result.kind != KIND_CLASS, o_result.class_id == 32'd0,
        "nonzero class id on non-token event")
    `CTSD_ASSERT_NEXT(a_sof_restarts_lines,
        i_accept && i_start_of_file, r_line_count == 32'd1 || r_line_count == 32'd2,
        "line count not restarted by start of file")

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
    import ctsd_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic [2:0] {
        PH_HEADER, PH_VERSION, PH_VARINT, PH_OLD_CMD, PH_OLD_DATA, PH_HALTED
    } t_parse_phase;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] class_id;
        logic [31:0] line_number;
    } t_token_event;

    typedef struct packed {
        logic         sof;
        logic [7:0]   data;
        logic         typed;
        logic         has_event;
        t_token_event ev;
    } t_stim_row;

    typedef struct packed {
        logic [31:0] first_line;
        logic [31:0] last_line;
        logic [31:0] delimiter;
        t_idle_mode  mode;
        logic        hold_off;
    } t_phase_cfg;

    // sof, byte, typed, has_event, {kind, class_id, line}
    localparam t_stim_row DIRECTED_ROWS [27] = '{
        '{1'b0, HEADER_MAGIC,   1'b1, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'h05,          1'b1, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'h85,          1'b1, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'h01,          1'b0, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'h00,          1'b1, 1'b1, '{KIND_LINE_END, 32'd0,          32'd1}},
        '{1'b0, 8'hFF,          1'b0, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'hFF,          1'b0, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'hFF,          1'b0, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'hFF,          1'b0, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'h0F,          1'b1, 1'b1, '{KIND_CLASS,    32'hFFFF_FFFF,  32'd2}},
        '{1'b1, 8'h01,          1'b1, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'hFF,          1'b1, 1'b1, '{KIND_CLASS,    32'd255,        32'd1}},
        '{1'b0, CMD_SKIP_GAP,   1'b1, 1'b1, '{KIND_SKIP_GAP, 32'd0,          32'd1}},
        '{1'b0, CMD_FLEX_GAP,   1'b1, 1'b1, '{KIND_FLEX_GAP, 32'd0,          32'd1}},
        '{1'b0, 8'hFF,          1'b1, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, CMD_LINE_END,   1'b1, 1'b1, '{KIND_LINE_END, 32'd0,          32'd1}},
        '{1'b0, 8'h04,          1'b1, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'h11,          1'b0, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'h22,          1'b0, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'h33,          1'b0, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'h44,          1'b1, 1'b1, '{KIND_CLASS,    32'h4433_2211,  32'd2}},
        '{1'b1, HEADER_MAGIC,   1'b1, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, OLD_VERSION,    1'b1, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b0, 8'h02,          1'b1, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b1, 8'h06,          1'b1, 1'b1, '{KIND_ERROR,    32'd0,          32'd1}},
        '{1'b0, 8'h00,          1'b1, 1'b0, '{KIND_CLASS,    32'd0,          32'd0}},
        '{1'b1, CMD_LINE_END,   1'b1, 1'b1, '{KIND_LINE_END, 32'd0,          32'd1}}
    };

    localparam t_phase_cfg PHASES [8] = '{
        '{32'd0,         32'd0,         32'hFFFF_FFFF, IDLE_NONE,     1'b1},
        '{32'd1,         32'd3,         32'd0,         IDLE_SENDER,   1'b0},
        '{32'd0,         32'hFFFF_FFFF, 32'd10,        IDLE_RECEIVER, 1'b0},
        '{32'd2,         32'd2,         32'd300,       IDLE_BOTH,     1'b0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,         IDLE_NONE,     1'b0},
        '{32'd5,         32'd2,         32'd127,       IDLE_SENDER,   1'b0},
        '{32'd0,         32'd4,         32'd1,         IDLE_RECEIVER, 1'b1},
        '{32'd0,         32'd0,         32'd0,         IDLE_BOTH,     1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = '0;
    logic        in_sof = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  out_kind;
    logic [31:0] out_class_id;
    logic [31:0] out_line;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // decoder state mirror
    logic [31:0]           first_line = '0;
    logic [31:0]           last_line = '0;
    logic [31:0]           delimiter = '0;
    t_parse_phase          phase = PH_HEADER;
    logic [VALUE_BITS-1:0] accum = '0;
    logic [2:0]            byte_pos = '0;
    logic [6:0]            bytes_left = '0;
    logic [31:0]           line_count = 32'd1;

    t_token_event expected_events [$];
    int failures = 0;
    int cycles = 0;
    int bytes_sent = 0;
    int sender_pct = 0;
    int receiver_pct = 0;
    int hold_requests = 0;
    int hold_taken = 0;
    int hold_left = 0;

    class_token_stream_decoder_core u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_in_data_byte     (in_byte),
        .i_in_start_of_file (in_sof),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_out_kind         (out_kind),
        .o_out_class_id     (out_class_id),
        .o_out_line_number  (out_line),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic bit coin(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit line_selected(input logic [31:0] line);
        if (first_line == 0 && last_line == 0) begin
            return 1'b1;
        end
        return line >= first_line && line <= last_line;
    endfunction

    function automatic bit post_event(input logic [2:0] kind, input logic [31:0] cls,
                                      input bit filtered, output t_token_event ev);
        ev = '{kind, cls, line_count};
        return !(filtered && !line_selected(line_count));
    endfunction

    function automatic bit close_line(output t_token_event ev);
        bit hit;
        hit = post_event(KIND_LINE_END, '0, 1'b1, ev);
        line_count = line_count + 32'd1;
        return hit;
    endfunction

    function automatic void add_digit(input logic [7:0] digit, input int shift);
        if (byte_pos < 7 && shift < VALUE_BITS) begin
            accum = accum + (VALUE_BITS'(digit) << shift);
        end
        if (byte_pos < 7) begin
            byte_pos = byte_pos + 3'd1;
        end
    endfunction

    function automatic bit old_command(input logic [7:0] c, output t_token_event ev);
        if (c == CMD_LINE_END) begin
            return close_line(ev);
        end
        if (c < CMD_SKIP_GAP) begin
            accum = '0;
            byte_pos = '0;
            bytes_left = (c > MAX_TOKEN_BYTES) ? 7'(MAX_TOKEN_BYTES) : c[6:0];
            phase = PH_OLD_DATA;
            return 1'b0;
        end
        if (c == CMD_SKIP_GAP) begin
            return post_event(KIND_SKIP_GAP, '0, 1'b1, ev);
        end
        if (c == CMD_FLEX_GAP) begin
            return post_event(KIND_FLEX_GAP, '0, 1'b1, ev);
        end
        return 1'b0;
    endfunction

    function automatic bit predict_event(input logic sof, input logic [7:0] b,
                                         output t_token_event ev);
        logic [31:0] value;
        ev = '0;
        if (sof) begin
            phase = PH_HEADER;
            accum = '0;
            byte_pos = '0;
            bytes_left = '0;
            line_count = 32'd1;
        end
        case (phase)
            PH_HEADER: begin
                if (b == HEADER_MAGIC) begin
                    phase = PH_VERSION;
                    return 1'b0;
                end
                if (b > HEADER_MAX_OLD) begin
                    phase = PH_HALTED;
                    return post_event(KIND_ERROR, '0, 1'b0, ev);
                end
                phase = PH_OLD_CMD;
                return old_command(b, ev);
            end
            PH_VERSION: begin
                phase = (b == OLD_VERSION) ? PH_OLD_CMD : PH_VARINT;
                accum = '0;
                byte_pos = '0;
                return 1'b0;
            end
            PH_VARINT: begin
                add_digit({1'b0, b[6:0]}, 7 * int'(byte_pos));
                if (b[7]) begin
                    return 1'b0;
                end
                value = 32'(accum);
                accum = '0;
                byte_pos = '0;
                if (value == delimiter) begin
                    return close_line(ev);
                end
                return post_event(KIND_CLASS, value, 1'b1, ev);
            end
            PH_OLD_CMD: begin
                return old_command(b, ev);
            end
            PH_OLD_DATA: begin
                add_digit(b, 8 * int'(byte_pos));
                if (bytes_left > 0) begin
                    bytes_left = bytes_left - 7'd1;
                end
                if (bytes_left != 0) begin
                    return 1'b0;
                end
                value = 32'(accum);
                accum = '0;
                byte_pos = '0;
                phase = PH_OLD_CMD;
                return post_event(KIND_CLASS, value, 1'b1, ev);
            end
            default: begin
                phase = PH_HALTED;
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // One byte transaction; a typed row overrides the predicted event.
    task automatic send_byte(input logic sof, input logic [7:0] b, input bit typed,
                             input bit typed_has, input t_token_event typed_ev);
        t_token_event ev;
        bit hit;
        @(negedge clk);
        while (coin(sender_pct)) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_sof = sof;
        in_byte = b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
        hit = predict_event(sof, b, ev);
        if (typed) begin
            hit = typed_has;
            ev = typed_ev;
        end
        if (hit) begin
            expected_events.insert(expected_events.size(), ev);
        end
    endtask

    task automatic push_byte(input logic sof, input logic [7:0] b);
        send_byte(sof, b, 1'b0, 1'b0, '0);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_FIRST_LINE:      first_line = val;
            CFG_LAST_LINE:       last_line = val;
            CFG_DELIMITER_CLASS: delimiter = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_events.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2: return delimiter;
            3, 4, 5: return 32'($urandom_range(0, 200));
            6:       return 32'hFFFF_FFFF;
            7:       return 32'd1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_varint(input logic [31:0] v);
        int pad;
        logic [7:0] b;
        pad = coin(8) ? $urandom_range(1, 5) : 0;
        do begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            b[7] = (v != 0) || (pad != 0);
            push_byte(1'b0, b);
        end while (v != 0);
        // overlong chain of random padding digits; digits past the value width are dropped
        while (pad > 0) begin
            pad--;
            push_byte(1'b0, {pad != 0, 7'($urandom)});
        end
    endtask

    task automatic send_varint_file();
        logic [7:0] version;
        push_byte(1'b1, HEADER_MAGIC);
        do version = 8'($urandom); while (version == OLD_VERSION);
        push_byte(1'b0, version);
        repeat ($urandom_range(1, 16)) send_varint(pick_value());
        if (coin(10)) begin
            push_byte(1'b0, {1'b1, 7'($urandom)});
        end
    endtask

    task automatic send_old_file(input bit with_magic);
        logic       sof;
        logic [7:0] c;
        int         n;
        sof = !with_magic;
        if (with_magic) begin
            push_byte(1'b1, HEADER_MAGIC);
            push_byte(1'b0, OLD_VERSION);
        end
        repeat ($urandom_range(1, 14)) begin
            if (sof) begin
                c = 8'($urandom_range(0, HEADER_MAX_OLD));
            end else begin
                case ($urandom_range(9))
                    0, 1, 2: c = CMD_LINE_END;
                    3:       c = CMD_SKIP_GAP;
                    4:       c = CMD_FLEX_GAP;
                    5:       c = 8'($urandom_range(130, 255));
                    default: c = coin(5) ? 8'(MAX_TOKEN_BYTES) : 8'($urandom_range(1, 8));
                endcase
            end
            push_byte(sof, c);
            sof = 1'b0;
            if (c != CMD_LINE_END && c < CMD_SKIP_GAP) begin
                n = coin(5) ? $urandom_range(0, c - 1) : int'(c);
                repeat (n) push_byte(1'b0, 8'($urandom));
                if (n < c) begin
                    return;
                end
            end
        end
    endtask

    always @(negedge clk) begin
        if (hold_requests != hold_taken) begin
            hold_taken = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready = 1'b0;
        end else begin
            out_ready = !coin(receiver_pct);
        end
    end

    always @(posedge clk) begin : check_events
        t_token_event want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_events.size() == 0) begin
                note_failure($sformatf("unexpected transaction: kind %0d class %0h line %0d",
                                       out_kind, out_class_id, out_line));
            end else begin
                want = expected_events.pop_front();
                if (out_kind !== want.kind || out_class_id !== want.class_id ||
                    out_line !== want.line_number) begin
                    note_failure($sformatf(
                        "mismatch: expected kind %0d class %0h line %0d, got %0d %0h %0d",
                        want.kind, want.class_id, want.line_number,
                        out_kind, out_class_id, out_line));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int target;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            send_byte(DIRECTED_ROWS[i].sof, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].has_event, DIRECTED_ROWS[i].ev);
        end

        foreach (PHASES[p]) begin
            settle();
            write_reg(CFG_FIRST_LINE, PHASES[p].first_line);
            write_reg(CFG_LAST_LINE, PHASES[p].last_line);
            write_reg(CFG_DELIMITER_CLASS, PHASES[p].delimiter);
            sender_pct = (PHASES[p].mode == IDLE_SENDER) ? 80 :
                         (PHASES[p].mode == IDLE_BOTH) ? 13 : 0;
            receiver_pct = (PHASES[p].mode == IDLE_RECEIVER) ? 80 :
                           (PHASES[p].mode == IDLE_BOTH) ? 13 : 0;
            if (PHASES[p].hold_off) begin
                hold_requests++;
            end
            target = bytes_sent + ITEMS_PER_PHASE;
            while (bytes_sent < target) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: send_varint_file();
                    5, 6:          send_old_file(1'b1);
                    7, 8:          send_old_file(1'b0);
                    default: begin
                        repeat ($urandom_range(1, 12)) push_byte(coin(15), 8'($urandom));
                    end
                endcase
            end
        end

        settle();
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
